@@ rtl/core/rti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// types and constants shared by the ray-triangle intersection core
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int DIST_W          = 31;
    localparam int CFG_ADDR_W      = 5;

    // register byte addresses (4 bytes apart)
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 5'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 5'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z = 5'd8;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_X    = 5'd12;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_Y    = 5'd16;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_Z    = 5'd20;
    localparam logic [CFG_ADDR_W-1:0] REG_DET_EPS  = 5'd24;

    typedef struct packed {
        logic signed [31:0] vertex0_x;
        logic signed [31:0] vertex0_y;
        logic signed [31:0] vertex0_z;
        logic signed [31:0] vertex1_x;
        logic signed [31:0] vertex1_y;
        logic signed [31:0] vertex1_z;
        logic signed [31:0] vertex2_x;
        logic signed [31:0] vertex2_y;
        logic signed [31:0] vertex2_z;
        logic               start_query;
        logic [DIST_W-1:0]  start_limit;
    } t_tri_req;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] best_out;
    } t_tri_rsp;

endpackage

@@ rtl/core/ray_triangle_intersect_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// moller-trumbore ray/triangle test with closest-hit distance register
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  request   in         i_valid/o_stall  t_tri_req (three vertices, query start)
//  result    out        o_valid/i_stall  t_tri_rsp (hit, best distance)
//  config    in         apb              origin, direction, det epsilon
//
//  a request runs the multiply steps, a check state and, when the checks
//  pass, the divide; the shared 33x34 multiplier (wide dot terms split in
//  a low and a high half) forms the products, the one-bit-a-cycle restoring
//  divider the distance; a miss skips the divide and the check state sets the result
//  the next request is taken only after the result side has taken the result
//  reset clears control state, best distance to all ones, det epsilon to 1
//  o_stall stays high while a request is in work or a result waits
//  the result register holds until the result side takes it
module ray_triangle_intersect_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  rti_pkg::t_tri_req             i_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rti_pkg::t_tri_rsp             o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rti_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rti_pkg::*;

    localparam int F   = COORD_FRAC_BITS;
    localparam int ACW = 100;   // accumulator width for dot products
    localparam int NW  = 115;   // numerator after the Q.F shift
    localparam int QW  = 33;    // quotient bits kept before saturation
    localparam int DCW = 6;
    localparam int HW  = 33;    // split point of a wide operand

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHECK, S_DIV, S_DONE
    } t_state;

    // configuration registers
    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic [DIST_W-1:0]  r_eps;
    logic [DIST_W-1:0]  r_best;

    // operand vectors
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [32:0] r_s  [3];
    logic signed [66:0] r_p  [3];
    logic signed [66:0] r_q  [3];
    logic signed [ACW-1:0] r_acc, r_a, r_su, r_sv, r_st;

    t_state          r_state;
    logic [5:0]      r_step;
    logic            r_hit;
    logic            r_valid;

    // divider
    logic [NW-1:0]   r_num;
    logic [ACW-1:0]  r_den;
    logic [ACW:0]    r_rem;
    logic [QW-1:0]   r_quo;
    logic [DCW:0]    r_dcnt;
    logic            r_sat;

    // ---------------- apb ----------------
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            REG_ORIGIN_X: prdata = r_org[0];
            REG_ORIGIN_Y: prdata = r_org[1];
            REG_ORIGIN_Z: prdata = r_org[2];
            REG_DIR_X:    prdata = r_dir[0];
            REG_DIR_Y:    prdata = r_dir[1];
            REG_DIR_Z:    prdata = r_dir[2];
            REG_DET_EPS:  prdata = {1'b0, r_eps};
            default:      prdata = '0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    // schedule: steps 0-5 build p (two products each), 6-11 q, then each
    // dot product takes six steps, low half of the wide term on the even
    // step and high half on the odd one: 12-17 a, 18-23 su, 24-29 sv, 30-35 st
    logic signed [32:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [66:0] wide_b;
    logic               use_wide;
    logic               mul_sh;    // high half, weight 2^33
    logic signed [66:0] mul_y;
    logic signed [ACW-1:0] mul_term;
    logic               mul_sub;   // subtract from accumulator
    logic               mul_clr;   // start a new sum

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        wide_b   = '0;
        use_wide = 1'b0;
        mul_sub  = 1'b0;
        mul_clr  = 1'b0;
        case (r_step)
            // p = dir x e2
            6'd0:  begin mul_a = 33'(r_dir[1]); mul_b = 34'(r_e2[2]); mul_clr = 1'b1; end
            6'd1:  begin mul_a = 33'(r_dir[2]); mul_b = 34'(r_e2[1]); mul_sub = 1'b1; end
            6'd2:  begin mul_a = 33'(r_dir[2]); mul_b = 34'(r_e2[0]); mul_clr = 1'b1; end
            6'd3:  begin mul_a = 33'(r_dir[0]); mul_b = 34'(r_e2[2]); mul_sub = 1'b1; end
            6'd4:  begin mul_a = 33'(r_dir[0]); mul_b = 34'(r_e2[1]); mul_clr = 1'b1; end
            6'd5:  begin mul_a = 33'(r_dir[1]); mul_b = 34'(r_e2[0]); mul_sub = 1'b1; end
            // q = s x e1
            6'd6:  begin mul_a = r_s[1]; mul_b = 34'(r_e1[2]); mul_clr = 1'b1; end
            6'd7:  begin mul_a = r_s[2]; mul_b = 34'(r_e1[1]); mul_sub = 1'b1; end
            6'd8:  begin mul_a = r_s[2]; mul_b = 34'(r_e1[0]); mul_clr = 1'b1; end
            6'd9:  begin mul_a = r_s[0]; mul_b = 34'(r_e1[2]); mul_sub = 1'b1; end
            6'd10: begin mul_a = r_s[0]; mul_b = 34'(r_e1[1]); mul_clr = 1'b1; end
            6'd11: begin mul_a = r_s[1]; mul_b = 34'(r_e1[0]); mul_sub = 1'b1; end
            // a = e1 . p
            6'd12, 6'd13: begin
                mul_a = r_e1[0]; wide_b = r_p[0]; use_wide = 1'b1; mul_clr = !r_step[0];
            end
            6'd14, 6'd15: begin mul_a = r_e1[1]; wide_b = r_p[1]; use_wide = 1'b1; end
            6'd16, 6'd17: begin mul_a = r_e1[2]; wide_b = r_p[2]; use_wide = 1'b1; end
            // su = s . p
            6'd18, 6'd19: begin
                mul_a = r_s[0]; wide_b = r_p[0]; use_wide = 1'b1; mul_clr = !r_step[0];
            end
            6'd20, 6'd21: begin mul_a = r_s[1]; wide_b = r_p[1]; use_wide = 1'b1; end
            6'd22, 6'd23: begin mul_a = r_s[2]; wide_b = r_p[2]; use_wide = 1'b1; end
            // sv = dir . q
            6'd24, 6'd25: begin
                mul_a = 33'(r_dir[0]); wide_b = r_q[0]; use_wide = 1'b1;
                mul_clr = !r_step[0];
            end
            6'd26, 6'd27: begin mul_a = 33'(r_dir[1]); wide_b = r_q[1]; use_wide = 1'b1; end
            6'd28, 6'd29: begin mul_a = 33'(r_dir[2]); wide_b = r_q[2]; use_wide = 1'b1; end
            // st = e2 . q
            6'd30, 6'd31: begin
                mul_a = r_e2[0]; wide_b = r_q[0]; use_wide = 1'b1; mul_clr = !r_step[0];
            end
            6'd32, 6'd33: begin mul_a = r_e2[1]; wide_b = r_q[1]; use_wide = 1'b1; end
            6'd34, 6'd35: begin mul_a = r_e2[2]; wide_b = r_q[2]; use_wide = 1'b1; end
            default: ;
        endcase
        // wide term = high half * 2^33 + unsigned low half
        if (use_wide) begin
            mul_b = r_step[0] ? wide_b[66:33] : {1'b0, wide_b[32:0]};
        end
        mul_sh   = use_wide & r_step[0];
        mul_y    = 67'(mul_a) * 67'(mul_b);
        mul_term = mul_sh ? (ACW'(mul_y) <<< HW) : ACW'(mul_y);
    end

    logic signed [ACW-1:0] acc_base, acc_sum;
    assign acc_base = mul_clr ? '0 : r_acc;
    assign acc_sum  = mul_sub ? acc_base - mul_term : acc_base + mul_term;

    // ---------------- checks ----------------
    logic a_neg;
    logic signed [ACW-1:0] a_abs, su_p, sv_p, st_p, uv_sum;
    logic [ACW-1:0] thr;
    logic pass;
    always_comb begin
        a_neg  = r_a[ACW-1];
        a_abs  = a_neg ? -r_a  : r_a;
        su_p   = a_neg ? -r_su : r_su;
        sv_p   = a_neg ? -r_sv : r_sv;
        st_p   = a_neg ? -r_st : r_st;
        uv_sum = su_p + sv_p;
        thr    = ACW'(r_eps) << (2 * F);
        pass   = (r_a != '0) && (a_abs >= $signed(thr)) &&
                 !su_p[ACW-1] && (su_p <= a_abs) &&
                 !sv_p[ACW-1] && (uv_sum <= a_abs) &&
                 !st_p[ACW-1] && (st_p != '0);
    end

    // ---------------- divider step ----------------
    logic [ACW:0] rem_sh, rem_dif;
    assign rem_sh  = {r_rem[ACW-1:0], r_num[NW-1]};
    assign rem_dif = rem_sh - {1'b0, r_den};

    // saturate when any quotient bit at or above bit 31 was ever set
    logic [DIST_W-1:0] t_val;
    assign t_val = (r_sat || (r_quo[QW-1:DIST_W] != '0)) ? '1 : r_quo[DIST_W-1:0];

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = '{hit: r_hit, best_out: r_best};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_step  <= '0;
            r_best  <= '1;
            r_eps   <= DIST_W'(1);
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= '0;
                r_dir[k] <= '0;
            end
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr)
                    REG_ORIGIN_X: r_org[0] <= pwdata;
                    REG_ORIGIN_Y: r_org[1] <= pwdata;
                    REG_ORIGIN_Z: r_org[2] <= pwdata;
                    REG_DIR_X:    r_dir[0] <= pwdata;
                    REG_DIR_Y:    r_dir[1] <= pwdata;
                    REG_DIR_Z:    r_dir[2] <= pwdata;
                    REG_DET_EPS:  r_eps    <= pwdata[DIST_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        // edge and origin vectors, exact in 33 bits
                        r_e1[0] <= 33'(i_req.vertex1_x) - 33'(i_req.vertex0_x);
                        r_e1[1] <= 33'(i_req.vertex1_y) - 33'(i_req.vertex0_y);
                        r_e1[2] <= 33'(i_req.vertex1_z) - 33'(i_req.vertex0_z);
                        r_e2[0] <= 33'(i_req.vertex2_x) - 33'(i_req.vertex0_x);
                        r_e2[1] <= 33'(i_req.vertex2_y) - 33'(i_req.vertex0_y);
                        r_e2[2] <= 33'(i_req.vertex2_z) - 33'(i_req.vertex0_z);
                        r_s[0]  <= 33'(r_org[0]) - 33'(i_req.vertex0_x);
                        r_s[1]  <= 33'(r_org[1]) - 33'(i_req.vertex0_y);
                        r_s[2]  <= 33'(r_org[2]) - 33'(i_req.vertex0_z);
                        if (i_req.start_query) r_best <= i_req.start_limit;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= acc_sum;
                    // store finished sums
                    case (r_step)
                        6'd1:  r_p[0] <= acc_sum[66:0];
                        6'd3:  r_p[1] <= acc_sum[66:0];
                        6'd5:  r_p[2] <= acc_sum[66:0];
                        6'd7:  r_q[0] <= acc_sum[66:0];
                        6'd9:  r_q[1] <= acc_sum[66:0];
                        6'd11: r_q[2] <= acc_sum[66:0];
                        6'd17: r_a    <= acc_sum;
                        6'd23: r_su   <= acc_sum;
                        6'd29: r_sv   <= acc_sum;
                        6'd35: r_st   <= acc_sum;
                        default: ;
                    endcase
                    if (r_step == 6'd35) r_state <= S_CHECK;
                    r_step <= r_step + 6'd1;
                end
                S_CHECK: begin
                    if (pass) begin
                        r_num   <= NW'(st_p) << F;
                        r_den   <= a_abs;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_sat   <= 1'b0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_hit   <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    // one restoring step per cycle over the numerator bits
                    if (!rem_dif[ACW]) r_rem <= rem_dif;
                    else               r_rem <= rem_sh;
                    r_num <= r_num << 1;
                    r_quo <= {r_quo[QW-2:0], !rem_dif[ACW]};
                    if (r_quo[QW-1:DIST_W] != '0) r_sat <= 1'b1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == (DCW+1)'(NW)) begin
                        r_state <= S_DONE;
                        if (t_val != '0 && t_val < r_best) begin
                            r_hit  <= 1'b1;
                            r_best <= t_val;
                        end else begin
                            r_hit  <= 1'b0;
                        end
                        r_valid <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
